// ===== design/pett_pkg.sv =====
// package for the periodic event timer table
// holds sizes, request and status codes, slot layout and memory request types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pett_pkg;

    localparam int ENTRIES     = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam int KIND_W   = 2;
    localparam int TYPE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [KIND_W-1:0] K_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] K_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] K_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] K_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

    typedef struct packed {
        logic [TYPE_W-1:0] slot_type;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] stamp;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_slot            wdata;
    } t_mem_req;

    typedef struct packed {
        logic                vld;
        logic [TYPE_W-1:0]   fired_type;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_evt;

endpackage

`default_nettype wire

// ===== design/pett_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/pett_ctrl.sv =====
// scan sequencer for the timer table: slot valid bits, read-modify-write of slot ram
// depends on pett_pkg
`timescale 1ns / 1ps
`default_nettype none

module pett_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [pett_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [pett_pkg::TYPE_W-1:0]      i_type_code,
    input  wire logic [pett_pkg::TIME_W-1:0]      i_period,
    input  wire logic [pett_pkg::TIME_W-1:0]      i_now,
    output pett_pkg::t_mem_req                    o_mem,
    input  wire logic [pett_pkg::SLOT_W-1:0]      i_rd_data,
    output pett_pkg::t_evt                        o_evt
);

    import pett_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic               r_chk_vld, n_chk_vld;
    logic               r_pend_vld, n_pend_vld;

    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [TYPE_W-1:0]  r_type, n_type;
    logic [TIME_W-1:0]  r_period, n_period;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_found_idx, n_found_idx;
    logic               r_empty_found, n_empty_found;
    logic [IDX_W-1:0]   r_empty_idx, n_empty_idx;
    logic [FCNT_W-1:0]  r_nfire, n_nfire;
    logic [TYPE_W-1:0]  r_pend_type, n_pend_type;

    t_slot              rd_slot;
    logic [TIME_W-1:0]  elapsed;
    t_mem_req           mem;
    t_evt               evt;

    assign rd_slot = t_slot'(i_rd_data);
    assign elapsed = r_now - rd_slot.stamp;

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_chk_vld     = r_chk_vld;
        n_pend_vld    = r_pend_vld;
        n_kind        = r_kind;
        n_type        = r_type;
        n_period      = r_period;
        n_now         = r_now;
        n_rd_idx      = r_rd_idx;
        n_chk_idx     = r_chk_idx;
        n_found       = r_found;
        n_found_idx   = r_found_idx;
        n_empty_found = r_empty_found;
        n_empty_idx   = r_empty_idx;
        n_nfire       = r_nfire;
        n_pend_type   = r_pend_type;
        mem           = '0;
        evt           = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_kind != K_NONE)) begin
                    n_kind        = i_kind;
                    n_type        = i_type_code;
                    n_period      = i_period;
                    n_now         = i_now;
                    n_rd_idx      = '0;
                    n_chk_vld     = 1'b0;
                    n_found       = 1'b0;
                    n_empty_found = 1'b0;
                    n_nfire       = '0;
                    n_pend_vld    = 1'b0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue the next slot read
                if (r_rd_idx != CNT_W'(ENTRIES)) begin
                    mem.re    = 1'b1;
                    mem.raddr = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                    n_state   = S_FIN;
                end
                // check the slot read last cycle
                if (r_chk_vld) begin
                    if (r_kind == K_TICK) begin
                        if (r_valid[r_chk_idx] && (elapsed >= rd_slot.period)
                            && (r_nfire != FCNT_W'(MAX_RESULTS))) begin
                            mem.we              = 1'b1;
                            mem.waddr           = r_chk_idx;
                            mem.wdata.slot_type = rd_slot.slot_type;
                            mem.wdata.period    = rd_slot.period;
                            mem.wdata.stamp     = r_now;
                            n_nfire             = r_nfire + 1'b1;
                            // previous fire is now known not to be the last one
                            if (r_pend_vld) begin
                                evt.vld        = 1'b1;
                                evt.fired_type = r_pend_type;
                                evt.status     = ST_FIRED;
                                evt.last       = 1'b0;
                            end
                            n_pend_vld  = 1'b1;
                            n_pend_type = rd_slot.slot_type;
                        end
                    end else begin
                        if (r_valid[r_chk_idx] && (rd_slot.slot_type == r_type) && !r_found) begin
                            n_found     = 1'b1;
                            n_found_idx = r_chk_idx;
                        end
                        if (!r_valid[r_chk_idx] && !r_empty_found) begin
                            n_empty_found = 1'b1;
                            n_empty_idx   = r_chk_idx;
                        end
                    end
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
                if (r_kind == K_TICK) begin
                    if (r_pend_vld) begin
                        evt.vld        = 1'b1;
                        evt.fired_type = r_pend_type;
                        evt.status     = ST_FIRED;
                        evt.last       = 1'b1;
                    end
                    n_pend_vld = 1'b0;
                end else begin
                    evt.vld        = 1'b1;
                    evt.fired_type = r_type;
                    evt.last       = 1'b1;
                    mem.wdata.slot_type = r_type;
                    mem.wdata.period    = r_period;
                    mem.wdata.stamp     = r_now;
                    if (r_kind == K_ADD) begin
                        if ((r_type == '0) || (r_period == '0)) begin
                            evt.status = ST_REJECTED;
                        end else if (r_found) begin
                            mem.we     = 1'b1;
                            mem.waddr  = r_found_idx;
                            evt.status = ST_UPDATED;
                        end else if (r_empty_found) begin
                            mem.we               = 1'b1;
                            mem.waddr            = r_empty_idx;
                            n_valid[r_empty_idx] = 1'b1;
                            evt.status           = ST_INSERTED;
                        end else begin
                            evt.status = ST_FULL;
                        end
                    end else begin
                        if (r_type == '0) begin
                            evt.status = ST_REJECTED;
                        end else if (r_found) begin
                            n_valid[r_found_idx] = 1'b0;
                            evt.status           = ST_REMOVED;
                        end else begin
                            evt.status = ST_NOTFOUND;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_chk_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_chk_vld  <= n_chk_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_type        <= n_type;
        r_period      <= n_period;
        r_now         <= n_now;
        r_rd_idx      <= n_rd_idx;
        r_chk_idx     <= n_chk_idx;
        r_found       <= n_found;
        r_found_idx   <= n_found_idx;
        r_empty_found <= n_empty_found;
        r_empty_idx   <= n_empty_idx;
        r_nfire       <= n_nfire;
        r_pend_type   <= n_pend_type;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_mem  = mem;
    assign o_evt  = evt;

endmodule

`default_nettype wire

// ===== design/periodic_event_timer_table_top.sv =====
// top level of the periodic event timer table: slot ram, scan sequencer, result register
// depends on pett_pkg, pett_ram, pett_ctrl
//
//  channel  | handshake            | ports
//  ---------+----------------------+--------------------------------------------
//  request  | start high, busy low | i_kind, i_type_code, i_period, i_now
//  result   | o_strobe, one cycle  | o_fired_type, o_status, o_last
//
// every tick, add or remove keeps busy high through a scan of all ENTRIES slots: one slot ram read
// per cycle, then the check of the last registered read, then the final write and status
// fire results of a tick come out during the scan, each held until the next fire is known;
// the last one, and every status result, strobes in the first cycle with busy low
// a request with kind 3 is taken and gives nothing; the receiver cannot stall
// reset is synchronous and clears all slots through their valid bits at once
`timescale 1ns / 1ps
`default_nettype none

module periodic_event_timer_table_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [pett_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [pett_pkg::TYPE_W-1:0]      i_type_code,
    input  wire logic [pett_pkg::TIME_W-1:0]      i_period,
    input  wire logic [pett_pkg::TIME_W-1:0]      i_now,
    output logic                                  o_strobe,
    output logic      [pett_pkg::TYPE_W-1:0]      o_fired_type,
    output logic      [pett_pkg::STATUS_W-1:0]    o_status,
    output logic                                  o_last
);

    import pett_pkg::*;

    t_mem_req            mem;
    logic [SLOT_W-1:0]   rd_data;
    t_evt                evt;

    logic                r_strobe;
    logic [TYPE_W-1:0]   r_fired_type;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;

    pett_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    pett_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_kind      (i_kind),
        .i_type_code (i_type_code),
        .i_period    (i_period),
        .i_now       (i_now),
        .o_mem       (mem),
        .i_rd_data   (rd_data),
        .o_evt       (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= evt.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt.vld) begin
            r_fired_type <= evt.fired_type;
            r_status     <= evt.status;
            r_last       <= evt.last;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_fired_type = r_fired_type;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ===== dv/pett_timer_checker.sv =====
// checker for the periodic event timer table: keeps its own copy of the slot table,
// predicts the results of every request transfer and compares each result transfer
// depends on pett_pkg
`timescale 1ns / 1ps

module pett_timer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [pett_pkg::KIND_W-1:0]   i_kind,
    input  logic [pett_pkg::TYPE_W-1:0]   i_type_code,
    input  logic [pett_pkg::TIME_W-1:0]   i_period,
    input  logic [pett_pkg::TIME_W-1:0]   i_now,
    input  logic                          i_strobe,
    input  logic [pett_pkg::TYPE_W-1:0]   i_fired_type,
    input  logic [pett_pkg::STATUS_W-1:0] i_status,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending
);

    import pett_pkg::*;

    typedef struct packed {
        logic [TYPE_W-1:0]   fired_type;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_timer_result;

    t_timer_result     due_results[$];
    logic [TYPE_W-1:0] tbl_type[ENTRIES];
    logic [TIME_W-1:0] tbl_period[ENTRIES];
    logic [TIME_W-1:0] tbl_stamp[ENTRIES];
    int                fail_cnt = 0;

    function automatic logic [STATUS_W-1:0] add_entry(input logic [TYPE_W-1:0] code,
                                                      input logic [TIME_W-1:0] per,
                                                      input logic [TIME_W-1:0] now);
        int hit;
        int free;
        hit  = -1;
        free = -1;
        if (code == '0 || per == '0)
            return ST_REJECTED;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (tbl_type[i] == code)
                hit = i;
            if (tbl_type[i] == '0)
                free = i;
        end
        if (hit >= 0) begin
            tbl_period[hit] = per;
            tbl_stamp[hit]  = now;
            return ST_UPDATED;
        end
        if (free < 0)
            return ST_FULL;
        tbl_type[free]   = code;
        tbl_period[free] = per;
        tbl_stamp[free]  = now;
        return ST_INSERTED;
    endfunction

    function automatic logic [STATUS_W-1:0] remove_entry(input logic [TYPE_W-1:0] code);
        int hit;
        hit = -1;
        if (code == '0)
            return ST_REJECTED;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (tbl_type[i] == code)
                hit = i;
        if (hit < 0)
            return ST_NOTFOUND;
        tbl_type[hit] = '0;
        return ST_REMOVED;
    endfunction

    // scan in slot order, restamp and queue every due slot up to the per-tick cap
    function automatic void fire_due_slots(input logic [TIME_W-1:0] now);
        int                fire_idx[MAX_RESULTS];
        int                n;
        logic [TIME_W-1:0] elapsed;
        t_timer_result     res;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            elapsed = now - tbl_stamp[i];
            if (n < MAX_RESULTS && tbl_type[i] != '0 && elapsed >= tbl_period[i]) begin
                tbl_stamp[i] = now;
                fire_idx[n]  = i;
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            res.fired_type = tbl_type[fire_idx[k]];
            res.status     = ST_FIRED;
            res.last       = (k == n - 1);
            due_results.push_back(res);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_timer_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                tbl_type[i] = '0;
        end else begin
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                             $time, i_fired_type, i_status, i_last);
                end else begin
                    want = due_results.pop_front();
                    check_field("fired_type", 32'(want.fired_type), 32'(i_fired_type));
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_start && !i_busy) begin
                case (i_kind)
                    K_TICK: begin
                        fire_due_slots(i_now);
                    end
                    K_ADD: begin
                        want.fired_type = i_type_code;
                        want.status     = add_entry(i_type_code, i_period, i_now);
                        want.last       = 1'b1;
                        due_results.push_back(want);
                    end
                    K_REMOVE: begin
                        want.fired_type = i_type_code;
                        want.status     = remove_entry(i_type_code);
                        want.last       = 1'b1;
                        due_results.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= due_results.size();
    end

endmodule

// ===== dv/periodic_event_timer_table_top_test.sv =====
// testbench top for the periodic event timer table: clock, reset, request stimulus and verdict
// directed corner requests, then random tick/add/remove/ignored-kind traffic in three idling phases
// depends on pett_pkg, periodic_event_timer_table_top, pett_timer_checker
`timescale 1ns / 1ps

module periodic_event_timer_table_top_test;
    import pett_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 43;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic [KIND_W-1:0]   i_kind      = K_TICK;
    logic [TYPE_W-1:0]   i_type_code = '0;
    logic [TIME_W-1:0]   i_period    = '0;
    logic [TIME_W-1:0]   i_now       = '0;
    logic                busy;
    logic                o_strobe;
    logic [TYPE_W-1:0]   o_fired_type;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;
    int                  fail_count;
    int                  pending;
    int                  idle_pct    = 20;
    int                  stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    periodic_event_timer_table_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_type_code  (i_type_code),
        .i_period     (i_period),
        .i_now        (i_now),
        .o_strobe     (o_strobe),
        .o_fired_type (o_fired_type),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    pett_timer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (i_kind),
        .i_type_code  (i_type_code),
        .i_period     (i_period),
        .i_now        (i_now),
        .i_strobe     (o_strobe),
        .i_fired_type (o_fired_type),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // start drops at random while the request waits, so gaps hit every scan phase
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TYPE_W-1:0] code,
                                input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] now);
        logic offer;
        logic taken;
        taken       = 1'b0;
        i_kind      <= kind;
        i_type_code <= code;
        i_period    <= per;
        i_now       <= now;
        while (!taken) begin
            offer = ($urandom_range(0, 99) >= idle_pct);
            start <= offer;
            @(posedge i_clk);
            taken = offer && !busy;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] time_base;
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] code;
        logic [TIME_W-1:0] per;
        int                r;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, rejects, absent remove, ignored kind
        send_request(K_TICK,   8'h00, 32'h0000_0000, 32'h0000_0000);
        send_request(K_ADD,    8'h00, 32'h0000_0005, 32'h0000_0000);
        send_request(K_ADD,    8'h05, 32'h0000_0000, 32'h0000_0000);
        send_request(K_REMOVE, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_request(K_REMOVE, 8'h09, 32'h0000_0000, 32'h0000_0000);
        send_request(K_NONE,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // fill every slot, then overflow and update
        send_request(K_ADD,    8'h01, 32'h0000_0001, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h80, 32'h8000_0000, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h7F, 32'h0000_000A, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h02, 32'h0000_0064, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h55, 32'h0000_0002, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'hAA, 32'h0000_0005, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h10, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h33, 32'h0000_0007, 32'hFFFF_FFF0);
        send_request(K_ADD,    8'h01, 32'h0000_0003, 32'hFFFF_FFF0);
        // wrapped elapsed time, nothing due, then every slot due at once
        send_request(K_TICK,   8'hFF, 32'hFFFF_FFFF, 32'h0000_0005);
        send_request(K_TICK,   8'h00, 32'h0000_0000, 32'h0000_0005);
        send_request(K_TICK,   8'h00, 32'h0000_0000, 32'hFFFF_FFEF);
        send_request(K_REMOVE, 8'hFF, 32'h0000_0000, 32'h0000_0000);
        send_request(K_REMOVE, 8'hFF, 32'h0000_0000, 32'h0000_0000);
        send_request(K_ADD,    8'h33, 32'h0000_0007, 32'h0000_0000);
        send_request(K_REMOVE, 8'h33, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // time base crosses the wrap during the random traffic
        time_base = 32'hFFFF_FC00;
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 84 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    kind = K_TICK;
                else if (r < 75)
                    kind = K_ADD;
                else if (r < 95)
                    kind = K_REMOVE;
                else
                    kind = K_NONE;
                // small type pool so updates, full table and hits on remove are common
                if ($urandom_range(0, 9) == 0)
                    code = TYPE_W'($urandom_range(0, 255));
                else
                    code = TYPE_W'($urandom_range(1, 10));
                r = $urandom_range(0, 19);
                if (r == 0)
                    per = $urandom;
                else if (r == 1)
                    per = '0;
                else
                    per = $urandom_range(1, 30);
                if ($urandom_range(0, 29) == 0)
                    time_base = $urandom;
                else
                    time_base = time_base + $urandom_range(0, 20);
                send_request(kind, code, per, time_base);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
